// ----- sv/htbd_pkg.sv -----
// Shared constants, types and tables for the code tree builder and decoder.
`timescale 1ns / 1ps
`default_nettype none
package htbd_pkg;

  localparam int NODE_COUNT   = 512;
  localparam int SYMBOL_COUNT = 256;
  localparam int NODE_W       = $clog2(NODE_COUNT);
  localparam int FREE_W       = $clog2(NODE_COUNT + 1);
  localparam int SYM_W        = 8;
  localparam int OP_W         = 2;
  localparam int ST_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_BUILD  = 2'd0,
    OP_END    = 2'd1,
    OP_DECODE = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMIT    = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } st_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_ALLOC,
    S_LEAF
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic link;
    logic clear_node;
    logic mark_leaf;
    logic build_step;
    logic leaf_read;
    logic dec_step;
    logic dec_root;
    logic emit;
    st_t  status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            child_zero;
    logic            table_full;
    logic            node_leaf;
    logic            out_free;
  } sts_t;

  typedef logic [255:0][SYM_W-1:0] sym_tab_t;

  // Reduction of an incoming symbol into the alphabet, resolved at elaboration.
  function automatic sym_tab_t build_sym_tab();
    sym_tab_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = SYM_W'(i % SYMBOL_COUNT);
    end
    return t;
  endfunction

  localparam sym_tab_t SYM_TAB = build_sym_tab();

endpackage
`default_nettype wire

// ----- sv/htbd_ctrl.sv -----
// Controller state machine that sequences each transaction through the node memory.
`timescale 1ns / 1ps
`default_nettype none
module htbd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire htbd_pkg::sts_t sts,
  output htbd_pkg::cmd_t     cmd
);
  import htbd_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = ST_OK;
    // Nothing is taken while reset is held.
    in_stall  = (state_r != S_IDLE) || !rst_n;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && rst_n) begin
          cmd.accept = 1'b1;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        unique case (sts.op)
          OP_BUILD: begin
            if (sts.child_zero && !sts.table_full) begin
              cmd.link  = 1'b1;
              state_nxt = S_ALLOC;
            end else if (sts.out_free) begin
              cmd.emit       = 1'b1;
              cmd.status     = sts.child_zero ? ST_FULL : ST_OK;
              cmd.build_step = !sts.child_zero;
              state_nxt      = S_IDLE;
            end
          end
          OP_END: begin
            if (sts.out_free) begin
              cmd.mark_leaf = 1'b1;
              cmd.emit      = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
          OP_DECODE: begin
            if (!sts.child_zero) begin
              cmd.leaf_read = 1'b1;
              state_nxt     = S_LEAF;
            end else if (sts.out_free) begin
              cmd.dec_root = 1'b1;
              cmd.emit     = 1'b1;
              cmd.status   = ST_MISSING;
              state_nxt    = S_IDLE;
            end
          end
          default: begin
            if (sts.out_free) begin
              cmd.emit  = 1'b1;
              state_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_ALLOC: begin
        if (sts.out_free) begin
          cmd.clear_node = 1'b1;
          cmd.emit       = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_LEAF: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.status   = sts.node_leaf ? ST_EMIT : ST_OK;
          cmd.dec_root = sts.node_leaf;
          cmd.dec_step = !sts.node_leaf;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/htbd_dp.sv -----
// Datapath: node memories, cursors, free index and the result register.
`timescale 1ns / 1ps
`default_nettype none
module htbd_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [htbd_pkg::OP_W-1:0]     in_opcode,
  input  wire logic                          in_code_bit,
  input  wire logic [htbd_pkg::SYM_W-1:0]    in_leaf_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [htbd_pkg::ST_W-1:0]          out_status,
  output logic [htbd_pkg::SYM_W-1:0]         out_decoded_symbol,
  input  wire htbd_pkg::cmd_t                cmd,
  output htbd_pkg::sts_t                     sts
);
  import htbd_pkg::*;

  // Child pointers and leaf flag with symbol, one entry per node.
  logic [NODE_W-1:0] left_mem  [NODE_COUNT];
  logic [NODE_W-1:0] right_mem [NODE_COUNT];
  logic [SYM_W:0]    ls_mem    [NODE_COUNT];

  logic [FREE_W-1:0] free_r;
  logic [NODE_W-1:0] build_cur_r;
  logic [NODE_W-1:0] dec_cur_r;
  logic              root_left_ok_r;
  logic              root_right_ok_r;
  logic              out_valid_r;
  logic [ST_W-1:0]   out_status_r;
  logic [SYM_W-1:0]  out_sym_r;

  logic [OP_W-1:0]   op_r;
  logic              bit_r;
  logic [SYM_W-1:0]  val_r;
  logic              rd_root_r;
  logic [NODE_W-1:0] left_q;
  logic [NODE_W-1:0] right_q;
  logic [SYM_W:0]    ls_q;
  logic [NODE_W-1:0] child_r;

  logic [NODE_W-1:0] rd_addr;
  logic [NODE_W-1:0] left_eff;
  logic [NODE_W-1:0] right_eff;
  logic [NODE_W-1:0] child;
  logic [NODE_W-1:0] new_node;
  logic              left_we;
  logic              right_we;
  logic              ls_we;
  logic [NODE_W-1:0] ptr_wd;
  logic [SYM_W:0]    ls_wd;
  logic              out_free;

  assign rd_addr   = (op_t'(in_opcode) == OP_DECODE) ? dec_cur_r : build_cur_r;
  // The root is never cleared by allocation, so its pointers read as empty until linked.
  assign left_eff  = (rd_root_r && !root_left_ok_r)  ? '0 : left_q;
  assign right_eff = (rd_root_r && !root_right_ok_r) ? '0 : right_q;
  assign child     = bit_r ? right_eff : left_eff;
  assign new_node  = free_r[NODE_W-1:0];

  assign left_we  = (cmd.link && !bit_r) || cmd.clear_node;
  assign right_we = (cmd.link && bit_r) || cmd.clear_node;
  assign ls_we    = cmd.mark_leaf || cmd.clear_node;
  assign ptr_wd   = cmd.link ? new_node : '0;
  assign ls_wd    = cmd.mark_leaf ? {1'b1, SYM_TAB[val_r]} : '0;
  assign out_free = !out_valid_r || !out_stall;

  assign sts.op         = op_r;
  assign sts.child_zero = (child == '0);
  assign sts.table_full = (free_r >= FREE_W'(NODE_COUNT));
  assign sts.node_leaf  = ls_q[SYM_W];
  assign sts.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (left_we) begin
      left_mem[build_cur_r] <= ptr_wd;
    end
    if (cmd.accept) begin
      left_q <= left_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (right_we) begin
      right_mem[build_cur_r] <= ptr_wd;
    end
    if (cmd.accept) begin
      right_q <= right_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[build_cur_r] <= ls_wd;
    end
    if (cmd.leaf_read) begin
      ls_q <= ls_mem[child];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_opcode;
      bit_r     <= in_code_bit;
      val_r     <= in_leaf_value;
      rd_root_r <= (rd_addr == '0);
    end
    if (cmd.leaf_read) begin
      child_r <= child;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.status;
      out_sym_r    <= (cmd.status == ST_EMIT) ? ls_q[SYM_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r          <= FREE_W'(1);
      build_cur_r     <= '0;
      dec_cur_r       <= '0;
      root_left_ok_r  <= 1'b0;
      root_right_ok_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cmd.link) begin
        free_r      <= free_r + FREE_W'(1);
        build_cur_r <= new_node;
        if (build_cur_r == '0) begin
          root_left_ok_r  <= root_left_ok_r || !bit_r;
          root_right_ok_r <= root_right_ok_r || bit_r;
        end
      end else if (cmd.build_step) begin
        build_cur_r <= child;
      end else if (cmd.mark_leaf) begin
        build_cur_r <= '0;
      end
      if (cmd.dec_root) begin
        dec_cur_r <= '0;
      end else if (cmd.dec_step) begin
        dec_cur_r <= child_r;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_decoded_symbol = out_sym_r;

endmodule
`default_nettype wire

// ----- sv/huffman_tree_build_and_decode.sv -----
// Top level of the bit-serial code tree builder and decoder.
//
// The input channel carries one transaction per code bit or command: an
// opcode, a branch bit and a leaf symbol. Build bits walk and grow the code
// tree in the node memory, an end-of-code transaction marks the current node
// as a leaf, and decode bits walk a separate cursor that reports the symbol
// when it reaches a leaf. Every input transaction yields exactly one result
// transaction carrying a status code and the decoded symbol.
// An item is accepted in the idle state and its result is registered from the
// look-up state, or from the allocate or leaf state when a build bit allocates
// a node or a decode bit finds a child and must look up its leaf flag. The next
// item is taken the cycle after the result is registered, since the registered
// read of the node memory must return the child at the cursor before the branch
// can be followed.
// Reset empties the tree to a bare root, sets the free index to one and puts
// both cursors at the root; no clearing pass is needed because every node is
// written when it is allocated. The input is stalled while reset is held.
// When the receiver stalls, the result stays in the output register and a
// following item waits in its last step until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module huffman_tree_build_and_decode (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [htbd_pkg::OP_W-1:0]     in_opcode,
  input  wire logic                          in_code_bit,
  input  wire logic [htbd_pkg::SYM_W-1:0]    in_leaf_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [htbd_pkg::ST_W-1:0]          out_status,
  output logic [htbd_pkg::SYM_W-1:0]         out_decoded_symbol
);
  import htbd_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  cmd_t cmd;
  sts_t sts;

  // The controller owns the input handshake and steps each transaction.
  htbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the tree, the cursors and the result register.
  htbd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_opcode          (in_opcode),
    .in_code_bit        (in_code_bit),
    .in_leaf_value      (in_leaf_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_decoded_symbol (out_decoded_symbol),
    .cmd                (cmd),
    .sts                (sts)
  );

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Self-checking testbench for the bit-serial code tree builder and decoder.
`timescale 1ns / 1ps
module tb;
  import htbd_pkg::*;

  // Opcode 3 has no member in the package enum; the block must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // A cycle with no transaction on either channel counts toward this limit.
  // The longest legal quiet stretch is the forced receiver hold-off plus the
  // steps of one item, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 120;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    st_t              status;
    logic [SYM_W-1:0] symbol;
  } result_t;

  // One row of the directed table. When has_exp is set the expected result
  // is the one typed into the row; otherwise the tree predictor supplies it.
  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             code_bit;
    logic [SYM_W-1:0] value;
    logic             has_exp;
    st_t              exp_status;
    logic [SYM_W-1:0] exp_symbol;
  } dir_row_t;

  typedef struct {
    logic [31:0] bits;
    int          len;
  } code_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // Decoding an empty tree finds no branch either way.
    '{OP_DECODE, 1'b0, 8'h00, 1'b1, ST_MISSING, 8'h00},
    '{OP_DECODE, 1'b1, 8'h00, 1'b1, ST_MISSING, 8'h00},
    // The unused opcode changes nothing.
    '{OP_UNUSED, 1'b1, 8'hFF, 1'b1, ST_OK,      8'h00},
    // An empty code marks the root as a leaf, but the root never emits.
    '{OP_END,    1'b0, 8'h5A, 1'b1, ST_OK,      8'h00},
    '{OP_DECODE, 1'b0, 8'h00, 1'b1, ST_MISSING, 8'h00},
    // Code 01 holds the top symbol, code 1 holds symbol zero.
    '{OP_BUILD,  1'b0, 8'h00, 1'b1, ST_OK,      8'h00},
    '{OP_BUILD,  1'b1, 8'h00, 1'b1, ST_OK,      8'h00},
    '{OP_END,    1'b0, 8'hFF, 1'b1, ST_OK,      8'h00},
    '{OP_BUILD,  1'b1, 8'h00, 1'b1, ST_OK,      8'h00},
    '{OP_END,    1'b1, 8'h00, 1'b1, ST_OK,      8'h00},
    '{OP_DECODE, 1'b0, 8'h00, 1'b0, ST_OK,      8'h00},
    '{OP_DECODE, 1'b1, 8'h00, 1'b0, ST_OK,      8'h00},
    '{OP_DECODE, 1'b1, 8'h00, 1'b0, ST_OK,      8'h00},
    // Left of the inner node does not exist.
    '{OP_DECODE, 1'b0, 8'h00, 1'b0, ST_OK,      8'h00},
    '{OP_DECODE, 1'b0, 8'h00, 1'b0, ST_OK,      8'h00},
    // Build code 10, walking on past the leaf at code 1.
    '{OP_BUILD,  1'b1, 8'h00, 1'b0, ST_OK,      8'h00},
    '{OP_BUILD,  1'b0, 8'h00, 1'b0, ST_OK,      8'h00},
    '{OP_END,    1'b0, 8'h80, 1'b0, ST_OK,      8'h00},
    // Decoding stops at the first leaf on the path.
    '{OP_DECODE, 1'b1, 8'h00, 1'b0, ST_OK,      8'h00},
    '{OP_BUILD,  1'b0, 8'h00, 1'b0, ST_OK,      8'h00},
    '{OP_BUILD,  1'b0, 8'h00, 1'b0, ST_OK,      8'h00},
    '{OP_END,    1'b1, 8'h01, 1'b0, ST_OK,      8'h00},
    '{OP_DECODE, 1'b0, 8'h00, 1'b0, ST_OK,      8'h00},
    '{OP_DECODE, 1'b0, 8'h00, 1'b0, ST_OK,      8'h00},
    '{OP_UNUSED, 1'b0, 8'h00, 1'b0, ST_OK,      8'h00}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [OP_W-1:0]  in_opcode = '0;
  logic             in_code_bit = 1'b0;
  logic [SYM_W-1:0] in_leaf_value = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ST_W-1:0]  out_status;
  logic [SYM_W-1:0] out_decoded_symbol;

  huffman_tree_build_and_decode dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_code_bit        (in_code_bit),
    .in_leaf_value      (in_leaf_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_decoded_symbol (out_decoded_symbol)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the node table and the two cursors. It is advanced once
  // per accepted input transaction, in acceptance order, so it always reflects
  // the block's architectural state after the last accepted item.
  logic [NODE_W-1:0] tree_left  [NODE_COUNT];
  logic [NODE_W-1:0] tree_right [NODE_COUNT];
  logic              tree_leaf  [NODE_COUNT];
  logic [SYM_W-1:0]  tree_sym   [NODE_COUNT];
  logic [FREE_W-1:0] tree_free;
  logic [NODE_W-1:0] build_at;
  logic [NODE_W-1:0] decode_at;

  result_t pending_results [$];
  code_t   known_codes [$];

  int mismatch_count = 0;
  int items_sent     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_token     = 0;

  task automatic clear_tree();
    for (int n = 0; n < NODE_COUNT; n++) begin
      tree_left[n]  = '0;
      tree_right[n] = '0;
      tree_leaf[n]  = 1'b0;
      tree_sym[n]   = '0;
    end
    tree_free = FREE_W'(1);
    build_at  = '0;
    decode_at = '0;
  endtask

  // Applies one item to the shadow tree and returns the result it causes.
  task automatic walk_tree(input logic [OP_W-1:0] op, input logic cbit,
                           input logic [SYM_W-1:0] value, output result_t res);
    logic [NODE_W-1:0] child;
    res.status = ST_OK;
    res.symbol = '0;
    case (op)
      OP_BUILD: begin
        child = cbit ? tree_right[build_at] : tree_left[build_at];
        if (child != '0) begin
          build_at = child;
        end else if (tree_free >= NODE_COUNT) begin
          // Table full: nothing is allocated and the cursor stays put.
          res.status = ST_FULL;
        end else begin
          child = tree_free[NODE_W-1:0];
          tree_free = tree_free + 1'b1;
          tree_left[child]  = '0;
          tree_right[child] = '0;
          tree_leaf[child]  = 1'b0;
          tree_sym[child]   = '0;
          if (cbit) begin
            tree_right[build_at] = child;
          end else begin
            tree_left[build_at] = child;
          end
          build_at = child;
        end
      end
      OP_END: begin
        tree_leaf[build_at] = 1'b1;
        tree_sym[build_at]  = SYM_W'(int'(value) % SYMBOL_COUNT);
        build_at = '0;
      end
      OP_DECODE: begin
        child = cbit ? tree_right[decode_at] : tree_left[decode_at];
        if (child == '0) begin
          res.status = ST_MISSING;
          decode_at = '0;
        end else if (tree_leaf[child]) begin
          res.status = ST_EMIT;
          res.symbol = tree_sym[child];
          decode_at = '0;
        end else begin
          decode_at = child;
        end
      end
      default: ;
    endcase
  endtask

  // Offers one input transaction and returns once it has been accepted. The
  // sender may first idle at random. Payload and valid change only at the
  // falling edge; acceptance is judged at the rising edge.
  task automatic send_item(input logic [OP_W-1:0] op, input logic cbit,
                           input logic [SYM_W-1:0] value, input logic has_exp,
                           input result_t typed);
    result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_code_bit   <= cbit;
    in_leaf_value <= value;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    walk_tree(op, cbit, value, res);
    pending_results.push_back(has_exp ? typed : res);
    items_sent++;
  endtask

  task automatic send_plain(input logic [OP_W-1:0] op, input logic cbit,
                            input logic [SYM_W-1:0] value);
    send_item(op, cbit, value, 1'b0, '0);
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return SYM_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_path(input logic [OP_W-1:0] op, input code_t c);
    for (int i = 0; i < c.len; i++) begin
      send_plain(op, c.bits[i], SYM_W'($urandom_range(255)));
    end
  endtask

  // Builds one code and closes it with a symbol; the code is remembered so
  // that later decode sequences can follow real paths through the tree.
  task automatic build_code(input int len);
    code_t c;
    c.bits = $urandom();
    c.len  = len;
    send_path(OP_BUILD, c);
    send_plain(OP_END, 1'($urandom_range(1)), pick_symbol());
    known_codes.push_back(c);
    if (known_codes.size() > 64) void'(known_codes.pop_front());
  endtask

  // Most random traffic is whole codes: build a code then end it, or decode
  // along a path that was built. The rest is loose bits, lone end-of-code items and ignored items.
  task automatic send_random_sequence();
    int    pick;
    code_t c;
    pick = $urandom_range(99);
    if (pick < 30) begin
      build_code(($urandom_range(7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6));
    end else if (pick < 75) begin
      if (known_codes.size() == 0) begin
        c.bits = $urandom();
        c.len  = $urandom_range(1, 6);
      end else begin
        c = known_codes[$urandom_range(known_codes.size() - 1)];
      end
      send_path(OP_DECODE, c);
    end else if (pick < 85) begin
      c.bits = $urandom();
      c.len  = $urandom_range(1, 4);
      send_path(OP_DECODE, c);
    end else if (pick < 92) begin
      send_plain(OP_UNUSED, 1'($urandom_range(1)), SYM_W'($urandom_range(255)));
    end else if (pick < 96) begin
      send_plain(OP_BUILD, 1'($urandom_range(1)), SYM_W'($urandom_range(255)));
    end else begin
      // Often lands on the root and so builds an empty code.
      send_plain(OP_END, 1'($urandom_range(1)), pick_symbol());
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("%s", what);
  endtask

  // Receiver. Normally stalls at random; when the stimulus asks for a
  // hold-off it keeps stall high until the hold-off runs out, so the result
  // register fills and the block in turn stalls the offered input.
  always @(negedge clk) begin : receiver
    static int hold_left = 0;
    static int hold_seen = 0;
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every accepted result transaction is checked against the oldest
  // expectation still waiting.
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d symbol %02h",
                                out_status, out_decoded_symbol));
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_decoded_symbol !== want.symbol) begin
          note_mismatch($sformatf(
              "result mismatch: expected status %0d symbol %02h, got status %0d symbol %02h",
              want.status, want.symbol, out_status, out_decoded_symbol));
        end
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  always @(posedge clk) begin : watchdog
    static int quiet = 0;
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int fill_rounds;
    clear_tree();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // First phase: sender idles lightly, receiver stalls heavily.
    send_idle_pct  = 28;
    recv_stall_pct = 66;
    for (int r = 0; r < DIR_ROWS; r++) begin
      send_item(DIRECTED[r].op, DIRECTED[r].code_bit, DIRECTED[r].value,
                DIRECTED[r].has_exp, '{DIRECTED[r].exp_status, DIRECTED[r].exp_symbol});
    end
    while (items_sent < 575) send_random_sequence();

    // Second phase: the roles of the two sides swap.
    send_idle_pct  = 66;
    recv_stall_pct = 28;
    while (items_sent < 1150) send_random_sequence();

    // Third phase: no idling. It opens with a long receiver hold-off while
    // the sender keeps offering back-to-back items.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_token++;
    while (items_sent < 1400) send_random_sequence();

    // Grow the tree with long codes until every node is in use, then keep
    // building so that allocations are refused as the table is full.
    fill_rounds = 0;
    while (tree_free < NODE_COUNT && fill_rounds < 200) begin
      build_code(24);
      fill_rounds++;
    end
    for (int k = 0; k < 6; k++) build_code(8);
    while (items_sent < 1850) send_random_sequence();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
